FILE: design/quadratic_slew_limiter_top_assert.svh
// ----------------------------------------------------------------------------
// quadratic_slew_limiter_top_assert.svh
// Assertion macros for the slew limiter top level
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_SLEW_LIMITER_TOP_ASSERT_SVH
`define QUADRATIC_SLEW_LIMITER_TOP_ASSERT_SVH

// checked out of reset
`define QSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define QSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/qsl_pkg.sv
// ----------------------------------------------------------------------------
// qsl_pkg
// Types, constants and saturation helpers of the quadratic slew limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qsl_pkg;

  localparam int unsigned NumStages = 9;

  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  localparam logic signed [31:0] GainReset = 32'sd98304;

  typedef enum logic [2:0] {
    REG_QUAD_COEFF  = 3'd0,
    REG_LIN_COEFF   = 3'd1,
    REG_CONST_COEFF = 3'd2,
    REG_IDLE_FLOOR  = 3'd3,
    REG_CROSS_GAIN  = 3'd4,
    REG_FLOOR_MODE  = 3'd5
  } reg_idx_e;

  // per-beat context carried down the pipe
  typedef struct packed {
    logic signed [31:0] tgt;
    logic signed [31:0] cur;
    logic [16:0]        stp;
    logic               err_pos;
    logic               err_neg;
    logic               same_sign;
  } ctx_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else begin
      r = v[32] ? SatMin : SatMax;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33] == v[32]) && (v[32] == v[31])) begin
      r = v[31:0];
    end else begin
      r = v[33] ? SatMin : SatMax;
    end
    return r;
  endfunction

  // q16.16 product back to q16.16: floor shift by 16, then saturate
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] p);
    logic signed [31:0] r;
    if ((p[63:47] == '0) || (p[63:47] == '1)) begin
      r = p[47:16];
    end else begin
      r = p[63] ? SatMin : SatMax;
    end
    return r;
  endfunction

endpackage

FILE: design/quadratic_slew_limiter_top.sv
// ----------------------------------------------------------------------------
// quadratic_slew_limiter_top
// Q16.16 slew limiter: steps an axis value toward its target at a rate set by
// a quadratic error law scaled by |accel|, floored, then clamped
// ----------------------------------------------------------------------------
// Fully pipelined: one beat enters per clock while the output is not stalled.
// The depth follows from the four dependent multiplications
// (coefficient times error, times error again, times |accel|, times the time
// step), each with its own register stage, plus the saturating stages around
// them. Each stage holds its beat when the next one is full, so stalls on the
// output side back up the pipe without losing or repeating beats, and bubbles
// are squeezed out. Configuration registers are written through a plain write
// port and should only change while the pipe is empty.
`timescale 1ns / 1ps
`include "quadratic_slew_limiter_top_assert.svh"

module quadratic_slew_limiter_top
  import qsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] target_value_i,
  input  logic signed [31:0] current_value_i,
  input  logic signed [31:0] accel_value_i,
  input  logic [16:0]        time_step_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] next_value_o
);

  // configuration registers
  logic signed [31:0] quad_coeff_q;
  logic signed [31:0] lin_coeff_q;
  logic signed [31:0] const_coeff_q;
  logic signed [31:0] idle_floor_q;
  logic signed [31:0] cross_gain_q;
  logic               floor_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_coeff_q  <= '0;
      lin_coeff_q   <= '0;
      const_coeff_q <= '0;
      idle_floor_q  <= '0;
      cross_gain_q  <= GainReset;
      floor_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_QUAD_COEFF:  quad_coeff_q  <= cfg_data_i;
        REG_LIN_COEFF:   lin_coeff_q   <= cfg_data_i;
        REG_CONST_COEFF: const_coeff_q <= cfg_data_i;
        REG_IDLE_FLOOR:  idle_floor_q  <= cfg_data_i;
        REG_CROSS_GAIN:  cross_gain_q  <= cfg_data_i;
        REG_FLOOR_MODE:  floor_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic [NumStages:1] v_q;
  logic [NumStages:1] en;

  always_comb begin
    en[NumStages] = !v_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = en[1];

  // context shift line
  ctx_t ctx_q [1:NumStages];
  ctx_t ctx_d;

  // stage 1: error, magnitudes, sign relations
  logic signed [32:0] err;
  logic signed [32:0] err_n;
  logic signed [32:0] acc_n;
  logic signed [32:0] cur_n;
  logic signed [31:0] es_d;
  logic signed [31:0] ea_d;
  logic signed [31:0] aa_d;
  logic signed [31:0] ca_d;

  always_comb begin
    err   = 33'(target_value_i) - 33'(current_value_i);
    err_n = 33'(current_value_i) - 33'(target_value_i);
    acc_n = 33'sd0 - 33'(accel_value_i);
    cur_n = 33'sd0 - 33'(current_value_i);
    es_d  = sat33(err);
    ea_d  = err[32] ? sat33(err_n) : sat33(err);
    aa_d  = accel_value_i[31] ? sat33(acc_n) : accel_value_i;
    ca_d  = current_value_i[31] ? sat33(cur_n) : current_value_i;

    ctx_d.tgt       = target_value_i;
    ctx_d.cur       = current_value_i;
    ctx_d.stp       = time_step_i;
    ctx_d.err_pos   = !err[32] && (err != '0);
    ctx_d.err_neg   = err[32];
    ctx_d.same_sign = (ctx_d.err_pos && !current_value_i[31] && (current_value_i != '0))
                   || (ctx_d.err_neg && current_value_i[31]);
  end

  logic signed [31:0] es1_q, ea1_q, aa1_q, ca1_q;
  logic signed [31:0] es2_q, aa2_q;
  logic signed [31:0] q1_3_q, ql3_q, fl3_q, es3_q, aa3_q;
  logic signed [31:0] ql4_q, fl4_q, aa4_q;
  logic signed [31:0] r0_5_q, fl5_q, aa5_q;
  logic signed [31:0] fl6_q;
  logic signed [31:0] rate7_q;
  logic signed [31:0] next9_q;

  logic signed [63:0] p_quad, p_lin, p_flr, p_sq, p_acc, p_move;

  // stage 2: first products
  qsl_mul u_mul_quad (
    .clk_i (clk_i), .en_i (en[2]), .a_i (quad_coeff_q), .b_i (es1_q), .p_o (p_quad)
  );
  qsl_mul u_mul_lin (
    .clk_i (clk_i), .en_i (en[2]), .a_i (lin_coeff_q), .b_i (ea1_q), .p_o (p_lin)
  );
  qsl_mul u_mul_flr (
    .clk_i (clk_i), .en_i (en[2]), .a_i (cross_gain_q), .b_i (ca1_q), .p_o (p_flr)
  );

  // stage 4: second factor of the squared term
  qsl_mul u_mul_sq (
    .clk_i (clk_i), .en_i (en[4]), .a_i (q1_3_q), .b_i (es3_q), .p_o (p_sq)
  );

  // stage 6: scale by |accel|
  qsl_mul u_mul_acc (
    .clk_i (clk_i), .en_i (en[6]), .a_i (r0_5_q), .b_i (aa5_q), .p_o (p_acc)
  );

  // stage 8: rate times time step
  qsl_mul u_mul_move (
    .clk_i (clk_i), .en_i (en[8]), .a_i (rate7_q),
    .b_i ($signed({15'd0, ctx_q[7].stp})), .p_o (p_move)
  );

  // stage 5 sum of the rate law terms
  logic signed [33:0] sum5;
  assign sum5 = 34'(sat_q(p_sq)) + 34'(ql4_q) + 34'(const_coeff_q);

  // stage 7 floor
  logic signed [31:0] r6;
  logic signed [31:0] rate7_d;

  always_comb begin
    r6 = sat_q(p_acc);
    if (!floor_mode_q) begin
      rate7_d = (r6 > idle_floor_q) ? r6 : idle_floor_q;
    end else if (!ctx_q[6].same_sign) begin
      rate7_d = (r6 > fl6_q) ? r6 : fl6_q;
    end else begin
      rate7_d = r6;
    end
  end

  // stage 9 step and clamp
  logic signed [33:0] cur9;
  logic signed [33:0] move9;
  logic signed [33:0] cand9;
  logic signed [31:0] lo9;
  logic signed [31:0] hi9;
  logic signed [31:0] next9_d;

  always_comb begin
    cur9  = 34'(ctx_q[8].cur);
    move9 = 34'(sat_q(p_move));
    if (ctx_q[8].err_pos) begin
      cand9 = cur9 + move9;
    end else if (ctx_q[8].err_neg) begin
      cand9 = cur9 - move9;
    end else begin
      cand9 = cur9;
    end
    lo9 = (ctx_q[8].tgt < ctx_q[8].cur) ? ctx_q[8].tgt : ctx_q[8].cur;
    hi9 = (ctx_q[8].tgt > ctx_q[8].cur) ? ctx_q[8].tgt : ctx_q[8].cur;
    if (cand9 < 34'(lo9)) begin
      next9_d = lo9;
    end else if (cand9 > 34'(hi9)) begin
      next9_d = hi9;
    end else begin
      next9_d = cand9[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ctx_q[1] <= ctx_d;
      es1_q    <= es_d;
      ea1_q    <= ea_d;
      aa1_q    <= aa_d;
      ca1_q    <= ca_d;
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (en[k]) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
    if (en[2]) begin
      es2_q <= es1_q;
      aa2_q <= aa1_q;
    end
    if (en[3]) begin
      q1_3_q <= sat_q(p_quad);
      ql3_q  <= sat_q(p_lin);
      fl3_q  <= sat_q(p_flr);
      es3_q  <= es2_q;
      aa3_q  <= aa2_q;
    end
    if (en[4]) begin
      ql4_q <= ql3_q;
      fl4_q <= fl3_q;
      aa4_q <= aa3_q;
    end
    if (en[5]) begin
      r0_5_q <= sat34(sum5);
      fl5_q  <= fl4_q;
      aa5_q  <= aa4_q;
    end
    if (en[6]) begin
      fl6_q <= fl5_q;
    end
    if (en[7]) begin
      rate7_q <= rate7_d;
    end
    if (en[9]) begin
      next9_q <= next9_d;
    end
  end

  assign out_valid_o  = v_q[NumStages];
  assign next_value_o = next9_q;

  // result never leaves the span between current and target
  `QSL_ASSERT(a_clamp_span, out_valid_o |-> ((next_value_o >= ctx_q[NumStages].tgt || next_value_o >= ctx_q[NumStages].cur) && (next_value_o <= ctx_q[NumStages].tgt || next_value_o <= ctx_q[NumStages].cur)), "next value outside current/target span")
  // zero error leaves the axis where it is
  `QSL_ASSERT(a_zero_err_hold, (out_valid_o && !ctx_q[NumStages].err_pos && !ctx_q[NumStages].err_neg) |-> (next_value_o == ctx_q[NumStages].cur), "zero error moved the axis")
  // input backs up only when every stage is full and the output is stalled
  `QSL_ASSERT(a_full_when_blocked, !in_ready_o |-> (v_q == '1 && !out_ready_i), "input blocked with room in the pipe")
  `QSL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output beat during reset")

endmodule

FILE: design/qsl_mul.sv
// ----------------------------------------------------------------------------
// qsl_mul
// Registered signed 32x32 multiplier stage with load enable
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qsl_mul
  import qsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;
  logic signed [63:0] p_d;

  assign p_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule
